/* rtl/core/klpq_pkg.sv */
// Shared types and constants for the key long-press qualifier.
`default_nettype none
package klpq_pkg;

  localparam int OP_W      = 3;
  localparam int EV_W      = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CENTER_W  = 10;
  localparam int TICK_W    = 16;
  localparam int PER_W     = 17;
  localparam int ADC_DRIFT = 70;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_EDGE    = 3'd1;
  localparam logic [OP_W-1:0] OP_ADC     = 3'd2;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;

  // Event codes of a result word.
  localparam logic [EV_W-1:0] EV_SHORT    = 3'd0;
  localparam logic [EV_W-1:0] EV_PWR      = 3'd1;
  localparam logic [EV_W-1:0] EV_PWR_REL  = 3'd2;
  localparam logic [EV_W-1:0] EV_MUTE     = 3'd3;
  localparam logic [EV_W-1:0] EV_LONG_REL = 3'd4;
  localparam logic [EV_W-1:0] EV_WAKE     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_USE_ADC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_REP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_GAP   = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted input word
    logic exec;     // apply the captured word to the key state
    logic rs_load;  // start a phase resync from the hold counter
    logic rs_step;  // one remainder step
    logic rs_done;  // last step: write the phases
  } klpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rs_pending;  // a period register changed since the last resync
    logic out_busy;    // the result register holds a word that is not taken
  } klpq_status_t;

endpackage
`default_nettype wire

/* rtl/core/klpq_ctrl.sv */
// Controller state machine for the key long-press qualifier.
`default_nettype none
module klpq_ctrl #(
  parameter int COUNT_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  klpq_pkg::klpq_status_t status_i,
  output klpq_pkg::klpq_cmd_t    cmd_o
);
  import klpq_pkg::*;

  localparam int CNT_W = $clog2(COUNT_BITS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_RESYNC = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (status_i.rs_pending) begin
          cmd_o.rs_load = 1'b1;
          cnt_d         = CNT_W'(COUNT_BITS - 1);
          state_d       = ST_RESYNC;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (!status_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_RESYNC: begin
        cmd_o.rs_step = 1'b1;
        if (cnt_q == '0) begin
          cmd_o.rs_done = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_ready_no_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.rs_pending && !cmd_o.rs_step)
    else $error("input taken while a resync is due or running");

  a_exec_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> state_q == ST_IDLE)
    else $error("controller did not return to idle after execute");

  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_EXEC)
    else $error("accepted word not followed by execute state");

endmodule
`default_nettype wire

/* rtl/core/klpq_datapath.sv */
// Datapath: configuration, key state, hold phases, remainder unit, result register.
`default_nettype none
module klpq_datapath #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 32
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  klpq_pkg::klpq_cmd_t             cmd_i,
  output klpq_pkg::klpq_status_t          status_o,
  input  wire                             cfg_we_i,
  input  wire [klpq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [klpq_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire [klpq_pkg::OP_W-1:0]        op_i,
  input  wire                             gpio_level_i,
  input  wire [SAMPLE_BITS-1:0]           adc_sample_i,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output logic [klpq_pkg::EV_W-1:0]       event_res_o
);
  import klpq_pkg::*;

  localparam int AW = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;
  localparam logic [COUNT_BITS-1:0] HOLD_MAX = '1;

  // Configuration registers.
  logic                use_adc_q, inv_level_q, wake_en_q;
  logic [CENTER_W-1:0] center_q;
  logic [TICK_W-1:0]   lp_cfg_q, rep_q, mute_q;

  // Captured input word.
  logic [OP_W-1:0]        op_q;
  logic                   lvl_q;
  logic [SAMPLE_BITS-1:0] smp_q;

  // Key state.
  logic armed_q, armed_d, key_q, key_d, adc_q, adc_d, long_q, long_d;
  logic susp_q, susp_d, swallow_q, swallow_d;
  logic [COUNT_BITS-1:0] hold_q, hold_d, stamp_q, stamp_d, tick_q, tick_d;
  logic [TICK_W-1:0] ph_lp_q, ph_lp_d;
  logic [PER_W-1:0]  ph_per_q, ph_per_d;

  // Remainder unit.
  logic                  dirty_q;
  logic [COUNT_BITS-1:0] hold_sh_q;
  logic [TICK_W-1:0]     rem_lp_q, rem_lp_nx;
  logic [PER_W-1:0]      rem_per_q, rem_per_nx;
  logic [TICK_W:0]       t_lp;
  logic [PER_W:0]        t_per;

  // Result register.
  logic            out_valid_q;
  logic [EV_W-1:0] event_q;

  logic [TICK_W-1:0]     lp;
  logic [PER_W-1:0]      per;
  logic [COUNT_BITS-1:0] tick_inc, gap;
  logic                  pressed, win, emit;
  logic [EV_W-1:0]       ev;
  logic [AW-1:0]         smp_ext, ctr_ext;

  // A long-press count of zero behaves as one.
  assign lp       = (lp_cfg_q == '0) ? TICK_W'(1) : lp_cfg_q;
  assign per      = {1'b0, lp} + {1'b0, rep_q};
  assign tick_inc = tick_q + 1'b1;
  assign gap      = tick_inc - stamp_q;
  assign pressed  = use_adc_q ? adc_q : (lvl_q ^ inv_level_q);

  // Window test center-70 < v < center+70, done without signs as v+70 > center.
  assign smp_ext = AW'(smp_q);
  assign ctr_ext = AW'(center_q);
  assign win     = (smp_ext < ctr_ext + AW'(ADC_DRIFT)) && (smp_ext + AW'(ADC_DRIFT) > ctr_ext);

  // One restoring remainder step for each divisor, hold counter bits fed from the top.
  always_comb begin
    t_lp  = {rem_lp_q, hold_sh_q[COUNT_BITS-1]};
    t_per = {rem_per_q, hold_sh_q[COUNT_BITS-1]};
    if (t_lp >= {1'b0, lp}) begin
      t_lp = t_lp - {1'b0, lp};
    end
    if (t_per >= {1'b0, per}) begin
      t_per = t_per - {1'b0, per};
    end
    rem_lp_nx  = t_lp[TICK_W-1:0];
    rem_per_nx = t_per[PER_W-1:0];
  end

  always_comb begin
    armed_d   = armed_q;
    key_d     = key_q;
    adc_d     = adc_q;
    long_d    = long_q;
    susp_d    = susp_q;
    swallow_d = swallow_q;
    hold_d    = hold_q;
    stamp_d   = stamp_q;
    tick_d    = tick_q;
    ph_lp_d   = ph_lp_q;
    ph_per_d  = ph_per_q;
    emit      = 1'b0;
    ev        = EV_SHORT;
    if (cmd_i.exec) begin
      case (op_q)
        OP_TICK: begin
          tick_d = tick_inc;
          if (armed_q) begin
            if (pressed) begin
              if (hold_q != '0) begin
                if (ph_per_q == '0) begin
                  emit = 1'b1;
                  ev   = EV_PWR_REL;
                end else if (ph_lp_q == '0) begin
                  emit    = 1'b1;
                  ev      = EV_PWR;
                  long_d  = 1'b1;
                  stamp_d = tick_inc;
                end
              end
              if (hold_q != HOLD_MAX) begin
                hold_d   = hold_q + 1'b1;
                ph_lp_d  = (ph_lp_q == lp - 1'b1) ? '0 : ph_lp_q + 1'b1;
                ph_per_d = (ph_per_q == per - 1'b1) ? '0 : ph_per_q + 1'b1;
              end
            end else begin
              armed_d = 1'b0;
              if (hold_q <= COUNT_BITS'(lp)) begin
                hold_d   = '0;
                ph_lp_d  = '0;
                ph_per_d = '0;
                if (long_q) begin
                  if (gap > COUNT_BITS'(mute_q)) begin
                    emit   = 1'b1;
                    ev     = EV_MUTE;
                    long_d = 1'b0;
                  end
                end else if (swallow_q) begin
                  swallow_d = 1'b0;
                end else begin
                  emit = 1'b1;
                  ev   = EV_SHORT;
                end
              end else if (key_q) begin
                emit = 1'b1;
                ev   = EV_LONG_REL;
              end
            end
            key_d = pressed;
          end
        end
        OP_EDGE: begin
          if (wake_en_q && susp_q) begin
            key_d = 1'b1;
            emit  = 1'b1;
            ev    = EV_WAKE;
          end
          hold_d   = '0;
          ph_lp_d  = '0;
          ph_per_d = '0;
          armed_d  = 1'b1;
        end
        OP_ADC: begin
          if (center_q != '0) begin
            adc_d = win;
            if (key_q != win) begin
              armed_d = 1'b1;
            end
          end
        end
        OP_SUSPEND: begin
          susp_d    = 1'b1;
          swallow_d = 1'b1;
        end
        OP_RESUME: begin
          susp_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.rs_done) begin
      ph_lp_d  = rem_lp_nx;
      ph_per_d = rem_per_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_adc_q   <= 1'b0;
      inv_level_q <= 1'b1;
      center_q    <= '0;
      wake_en_q   <= 1'b0;
      lp_cfg_q    <= TICK_W'(100);
      rep_q       <= TICK_W'(100);
      mute_q      <= TICK_W'(130);
      dirty_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_USE_ADC:    use_adc_q   <= cfg_data_i[0];
          REG_INV_LEVEL:  inv_level_q <= cfg_data_i[0];
          REG_ADC_CENTER: center_q    <= cfg_data_i[CENTER_W-1:0];
          REG_WAKE_EN:    wake_en_q   <= cfg_data_i[0];
          REG_LONG_PRESS: lp_cfg_q    <= cfg_data_i[TICK_W-1:0];
          REG_HOLD_REP:   rep_q       <= cfg_data_i[TICK_W-1:0];
          REG_MUTE_GAP:   mute_q      <= cfg_data_i[TICK_W-1:0];
          default: begin
          end
        endcase
      end
      // A new period invalidates the phase counters until they are recomputed.
      if (cfg_we_i && (cfg_idx_i == REG_LONG_PRESS || cfg_idx_i == REG_HOLD_REP)) begin
        dirty_q <= 1'b1;
      end else if (cmd_i.rs_load) begin
        dirty_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      key_q       <= 1'b0;
      adc_q       <= 1'b0;
      long_q      <= 1'b0;
      susp_q      <= 1'b0;
      swallow_q   <= 1'b0;
      hold_q      <= '0;
      stamp_q     <= '0;
      tick_q      <= '0;
      ph_lp_q     <= '0;
      ph_per_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q   <= armed_d;
      key_q     <= key_d;
      adc_q     <= adc_d;
      long_q    <= long_d;
      susp_q    <= susp_d;
      swallow_q <= swallow_d;
      hold_q    <= hold_d;
      stamp_q   <= stamp_d;
      tick_q    <= tick_d;
      ph_lp_q   <= ph_lp_d;
      ph_per_q  <= ph_per_d;
      if (cmd_i.exec && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      lvl_q <= gpio_level_i;
      smp_q <= adc_sample_i;
    end
    if (cmd_i.exec && emit) begin
      event_q <= ev;
    end
    if (cmd_i.rs_load) begin
      hold_sh_q <= hold_q;
      rem_lp_q  <= '0;
      rem_per_q <= '0;
    end else if (cmd_i.rs_step) begin
      hold_sh_q <= {hold_sh_q[COUNT_BITS-2:0], 1'b0};
      rem_lp_q  <= rem_lp_nx;
      rem_per_q <= rem_per_nx;
    end
  end

  assign status_o.rs_pending = dirty_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign event_res_o         = event_q;

  a_zero_hold_zero_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q == '0 |-> ph_lp_q == '0 && ph_per_q == '0)
    else $error("phase counters out of step with a cleared hold counter");

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !(out_valid_q && !out_ready_i))
    else $error("execute while the result register is still occupied");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && emit |=> out_valid_q && event_q == $past(ev))
    else $error("emitted event not captured in the result register");

endmodule
`default_nettype wire

/* rtl/core/key_long_press_qualifier_core.sv */
// Top level of the key long-press qualifier: controller and datapath.
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          op, gpio_level, adc_sample
// m_axis    out  tvalid/tready          event_res
// cfg       in   cfg_we_i, no wait      cfg_idx_i selects, cfg_data_i value
//
// Each input word is accepted and captured in the idle state, then applied to the
// key state in the execute state. The execute state waits while the one-entry result
// register still holds an untaken word; input is taken while a result waits.
// A write to the long-press or the hold-repeat register starts a resync of the
// hold phase counters by a serial remainder unit, during which no input word is
// accepted. Reset is asynchronous and needs no clearing pass.
module key_long_press_qualifier_core #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: op[2:0], gpio_level[3], adc_sample[SAMPLE_BITS+3:4].
  input  wire [((SAMPLE_BITS + 4 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // Fields from bit 0: event_res[2:0].
  output logic [7:0]                            m_axis_tdata,
  input  wire                                   cfg_we_i,
  input  wire [klpq_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire [klpq_pkg::CFG_W-1:0]             cfg_data_i
);
  import klpq_pkg::*;

  klpq_cmd_t    cmd;
  klpq_status_t status;
  logic [EV_W-1:0] event_res;

  klpq_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  klpq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (s_axis_tdata[OP_W-1:0]),
    .gpio_level_i (s_axis_tdata[OP_W]),
    .adc_sample_i (s_axis_tdata[OP_W+1 +: SAMPLE_BITS]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .event_res_o  (event_res)
  );

  assign m_axis_tdata = {(8 - EV_W)'(0), event_res};

endmodule
`default_nettype wire
